[rtl/core/ddd_pkg.sv]
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared widths, constants and the month offset table for the Gregorian
// day count core.
// ----------------------------------------------------------------------------
package ddd_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int CNT_W   = 22;

   // bus widths, packed fields rounded up to whole bytes
   localparam int DATE_W     = YEAR_W + MONTH_W + DAY_W;
   localparam int REQ_DATA_W = ((2 * DATE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CNT_W + 7) / 8) * 8;

   // years above this saturate
   localparam int YEAR_MAX  = 9999;
   localparam int MONTH_MAX = 11;

   // day number of the last date of YEAR_MAX fits in DN_W bits
   localparam int DN_W  = $clog2(YEAR_MAX * 366 + 400);
   localparam int OFS_W = 9;

   // divide by 100: floor(x * 5243 / 2^19), exact for x below 43699
   localparam int DIV100_MUL = 5243;
   localparam int DIV100_SH  = 19;
   localparam int MUL_W      = 13;
   localparam int PROD_W     = YEAR_W + MUL_W;
   localparam int QUO_W      = PROD_W - DIV100_SH;

   localparam int DAYS_PER_YEAR = 365;
   localparam int CENTURY       = 100;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [QUO_W-1:0]   quo_type;
   typedef logic [DN_W-1:0]    dnum_type;
   typedef logic [OFS_W-1:0]   ofs_type;

   // days before each month, common and leap year
   localparam ofs_type BEFORE_COMMON [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };
   localparam ofs_type BEFORE_LEAP [12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

   // month must already be saturated to 0..11
   function automatic ofs_type month_offset(input logic leap, input month_type m);
      ofs_type r;
      r = '0;
      for (int k = 0; k <= MONTH_MAX; k++) begin
         if (m == MONTH_W'(k)) begin
            r = leap ? BEFORE_LEAP[k] : BEFORE_COMMON[k];
         end
      end
      return r;
   endfunction

endpackage

[rtl/core/date_difference_in_days_core.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days_core
// Days from a start date to an end date on the Gregorian calendar, with an
// order flag when the start lies after the end.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  req_    | in        | start date and end date (year, month 0..11, day)
//  rsp_    | out       | day count in tdata, order error in tuser
//
//  Four register stages: saturate and multiply by the 1/100 reciprocal,
//  year base and leap rule, month offset and day, compare and subtract.
//  One transaction per cycle unless rsp_ stalls; results leave in order.
//  All stages advance together; a stalled rsp_ output freezes the pipeline
//  and drops req_tready in the same cycle. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module date_difference_in_days_core
   import ddd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // start_year, start_month, start_day, end_year, end_month, end_day, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // day_count, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // order_error
   output logic                  rsp_tuser
);

   logic advance;

   // stage 1: saturated date and reciprocal products
   logic      s1_vld_ff;
   year_type  s1_year_ff  [2];
   year_type  s1_year_in  [2];
   month_type s1_month_ff [2];
   month_type s1_month_in [2];
   day_type   s1_day_ff   [2];
   day_type   s1_day_in   [2];
   prod_type  s1_pn_ff    [2];
   prod_type  s1_pn_in    [2];
   prod_type  s1_py_ff    [2];
   prod_type  s1_py_in    [2];

   // stage 2: days before the year, leap flag
   logic      s2_vld_ff;
   dnum_type  s2_base_ff  [2];
   dnum_type  s2_base_in  [2];
   logic      s2_leap_ff  [2];
   logic      s2_leap_in  [2];
   month_type s2_month_ff [2];
   day_type   s2_day_ff   [2];

   // stage 3: day numbers
   logic      s3_vld_ff;
   dnum_type  s3_dn_ff    [2];
   dnum_type  s3_dn_in    [2];

   // stage 4: output register
   logic             s4_vld_ff;
   logic [CNT_W-1:0] s4_cnt_ff;
   logic [CNT_W-1:0] s4_cnt_in;
   logic             s4_err_ff;
   logic             s4_err_in;

   // whole pipeline moves when the output slot is free or being taken
   assign advance    = !s4_vld_ff || rsp_tready;
   assign req_tready = advance;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // stage 1: unpack, saturate, multiply y-1 and y by the reciprocal of 100
   always_comb begin
      year_type  yr;
      month_type mo;
      for (int i = 0; i < 2; i++) begin
         yr = req_tdata[i*DATE_W +: YEAR_W];
         mo = req_tdata[i*DATE_W + YEAR_W +: MONTH_W];
         s1_year_in[i]  = (yr > YEAR_W'(YEAR_MAX)) ? YEAR_W'(YEAR_MAX) : yr;
         s1_month_in[i] = (mo > MONTH_W'(MONTH_MAX)) ? MONTH_W'(MONTH_MAX) : mo;
         s1_day_in[i]   = req_tdata[i*DATE_W + YEAR_W + MONTH_W +: DAY_W];
         s1_pn_in[i]    = PROD_W'(s1_year_in[i] - YEAR_W'(1)) * PROD_W'(DIV100_MUL);
         s1_py_in[i]    = PROD_W'(s1_year_in[i]) * PROD_W'(DIV100_MUL);
      end
   end

   // stage 2: 365*y + n/4 - n/100 + n/400 with n = y-1, and the leap rule
   always_comb begin
      quo_type  qn;
      quo_type  qy;
      year_type nm1;
      for (int i = 0; i < 2; i++) begin
         qn  = s1_pn_ff[i][DIV100_SH +: QUO_W];
         qy  = s1_py_ff[i][DIV100_SH +: QUO_W];
         nm1 = s1_year_ff[i] - YEAR_W'(1);
         if (s1_year_ff[i] == '0) begin
            s2_base_in[i] = '0;
         end else begin
            s2_base_in[i] = DN_W'(s1_year_ff[i]) * DN_W'(DAYS_PER_YEAR)
                          + DN_W'(nm1 >> 2) - DN_W'(qn) + DN_W'(qn >> 2);
         end
         // divisible by 4, and either not by 100 or by 400; year zero is common
         s2_leap_in[i] = (s1_year_ff[i] != '0) && (s1_year_ff[i][1:0] == 2'b00)
                      && ((s1_year_ff[i] != YEAR_W'(qy) * YEAR_W'(CENTURY))
                          || (qy[1:0] == 2'b00));
      end
   end

   // stage 3: add month offset and day
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s3_dn_in[i] = s2_base_ff[i]
                     + DN_W'(month_offset(s2_leap_ff[i], s2_month_ff[i]))
                     + DN_W'(s2_day_ff[i]);
      end
   end

   // stage 4: order check and difference (index 0 is start, 1 is end)
   always_comb begin
      s4_err_in = s3_dn_ff[0] > s3_dn_ff[1];
      s4_cnt_in = s4_err_in ? '0 : CNT_W'(s3_dn_ff[1] - s3_dn_ff[0]);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 2; i++) begin
            s1_year_ff[i]  <= s1_year_in[i];
            s1_month_ff[i] <= s1_month_in[i];
            s1_day_ff[i]   <= s1_day_in[i];
            s1_pn_ff[i]    <= s1_pn_in[i];
            s1_py_ff[i]    <= s1_py_in[i];
            s2_base_ff[i]  <= s2_base_in[i];
            s2_leap_ff[i]  <= s2_leap_in[i];
            s2_month_ff[i] <= s1_month_ff[i];
            s2_day_ff[i]   <= s1_day_ff[i];
            s3_dn_ff[i]    <= s3_dn_in[i];
         end
         s4_cnt_ff <= s4_cnt_in;
         s4_err_ff <= s4_err_in;
      end
   end

   assign rsp_tvalid = s4_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(s4_cnt_ff);
   assign rsp_tuser  = s4_err_ff;

endmodule

[rtl/core/ddd_checker.sv]
// ----------------------------------------------------------------------------
// ddd_checker
// Port-level checks for the day count core, bound to the core module.
// ----------------------------------------------------------------------------
module ddd_checker
   import ddd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // the flagged case always reports a zero count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("order error with nonzero day count");

   // input backpressure only comes from a held result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

   // pipeline empties on reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an offered transaction carries known data
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tdata))
      else $error("req_tdata unknown while req_tvalid is high");

endmodule

bind date_difference_in_days_core ddd_checker u_ddd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
